/* rtl/core/swerve_module_kinematics_top_assert.svh */
// Assertion macros for the swerve module kinematics block.
`ifndef SWERVE_MODULE_KINEMATICS_TOP_ASSERT_SVH
`define SWERVE_MODULE_KINEMATICS_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SMK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SMK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/core/smk_pkg.sv */
package smk_pkg;

  localparam int CordicStages = 16;
  localparam int NStg = (CordicStages > 24) ? 24 : CordicStages;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 14;
  localparam int NumRegs = 8;

  // Velocity width, Q.16 inches per second
  localparam int VelW = 34;
  // CORDIC datapath width
  localparam int CorW = 32;

  localparam logic [16:0] KLin = 17'd51603;
  localparam logic [13:0] KRot = 14'd6487;
  localparam logic signed [15:0] RotDeadband = 16'sd1280;
  localparam logic [31:0] InvGain = 32'd2608131496;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic signed [32:0] QuarterTurn = 33'sh0_4000_0000;

  typedef enum logic [0:0] {
    OP_ROBOT = 1'b0,
    OP_FIELD = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MOD_FR = 2'd0,
    MOD_FL = 2'd1,
    MOD_BR = 2'd2,
    MOD_BL = 2'd3
  } mod_idx_t;

  typedef struct packed {
    logic [0:0]         opcode;
    logic signed [15:0] stick_forward;
    logic signed [15:0] stick_sideways;
    logic signed [15:0] rotate_command;
    logic signed [15:0] heading;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         module_index;
    logic signed [15:0] wheel_angle;
    logic [15:0]        spd_q7;
    logic               last_module;
  } res_t;

  typedef struct packed {
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
    logic signed [VelW-1:0] w;
  } vel_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'd536870912;
      5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;
      5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;
      5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/smk_stream_if.sv */
interface smk_stream_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/smk_cmd_front.sv */
// Command front end: scale sticks and rotation, heading rotation in field mode.
module smk_cmd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  smk_pkg::cmd_t       in_cmd,
  output logic                out_vld,
  output smk_pkg::vel_t       out_vel
);
  import smk_pkg::*;

  // stage A: products
  logic                   a_vld_r;
  logic signed [33:0]     a_px_r, a_py_r;
  logic signed [30:0]     a_pw_r;
  logic                   a_field_r, a_dead_r;
  logic [31:0]            a_z_r;

  logic signed [33:0]     px_nxt, py_nxt;
  logic signed [16:0]     fwd_e, side_e;

  always_comb begin
    fwd_e = (in_cmd.opcode == OP_FIELD) ? -17'(in_cmd.stick_forward)
                                        : 17'(in_cmd.stick_forward);
    side_e = (in_cmd.opcode == OP_FIELD) ? -17'(in_cmd.stick_sideways)
                                         : 17'(in_cmd.stick_sideways);
    px_nxt = 34'(fwd_e) * $signed({1'b0, KLin});
    py_nxt = 34'(side_e) * $signed({1'b0, KLin});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
    end
    if (adv) begin
      a_px_r <= px_nxt;
      a_py_r <= py_nxt;
      a_pw_r <= 31'(in_cmd.rotate_command) * $signed({1'b0, KRot});
      a_field_r <= (in_cmd.opcode == OP_FIELD);
      a_dead_r <= (in_cmd.rotate_command > -RotDeadband) &&
                  (in_cmd.rotate_command < RotDeadband);
      a_z_r <= {16'(16'd0 - in_cmd.heading), 16'd0};
    end
  end

  // stage B: pre-rotation into the right half plane
  logic                   b_vld_r;
  logic signed [CorW-1:0] b_x_r, b_y_r;
  logic signed [VelW-1:0] b_w_r;
  logic                   b_field_r;
  logic [31:0]            b_z_r;
  logic signed [CorW-1:0] ax, ay;
  logic signed [32:0]     zs;
  logic                   flip;

  always_comb begin
    ax = CorW'(a_px_r >>> 8);
    ay = CorW'(a_py_r >>> 8);
    zs = 33'($signed(a_z_r));
    flip = a_field_r && ((zs > QuarterTurn) || (zs < -QuarterTurn));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
    if (adv) begin
      b_x_r <= flip ? -ax : ax;
      b_y_r <= flip ? -ay : ay;
      b_z_r <= flip ? a_z_r + HalfTurn : a_z_r;
      b_field_r <= a_field_r;
      b_w_r <= (a_field_r && a_dead_r) ? '0 : VelW'(a_pw_r >>> 8);
    end
  end

  // CORDIC rotation stages
  logic                   c_vld_r [NStg+1];
  logic signed [CorW-1:0] c_x_r [NStg+1];
  logic signed [CorW-1:0] c_y_r [NStg+1];
  logic [31:0]            c_z_r [NStg+1];
  logic signed [VelW-1:0] c_w_r [NStg+1];
  logic                   c_f_r [NStg+1];

  always_comb begin
    c_vld_r[0] = b_vld_r;
    c_x_r[0] = b_x_r;
    c_y_r[0] = b_y_r;
    c_z_r[0] = b_z_r;
    c_w_r[0] = b_w_r;
    c_f_r[0] = b_field_r;
  end

  for (genvar i = 0; i < NStg; i++) begin : g_rot
    logic signed [CorW-1:0] xs, ys;
    logic                   pos;
    always_comb begin
      xs = c_x_r[i] >>> i;
      ys = c_y_r[i] >>> i;
      pos = !c_z_r[i][31];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        c_vld_r[i+1] <= c_vld_r[i];
      end
      if (adv) begin
        c_w_r[i+1] <= c_w_r[i];
        c_f_r[i+1] <= c_f_r[i];
        if (!c_f_r[i]) begin
          c_x_r[i+1] <= c_x_r[i];
          c_y_r[i+1] <= c_y_r[i];
          c_z_r[i+1] <= c_z_r[i];
        end else if (pos) begin
          c_x_r[i+1] <= c_x_r[i] - ys;
          c_y_r[i+1] <= c_y_r[i] + xs;
          c_z_r[i+1] <= c_z_r[i] - atan_lut(5'(i));
        end else begin
          c_x_r[i+1] <= c_x_r[i] + ys;
          c_y_r[i+1] <= c_y_r[i] - xs;
          c_z_r[i+1] <= c_z_r[i] + atan_lut(5'(i));
        end
      end
    end
  end

  // gain removal
  logic                   g_vld_r;
  logic signed [CorW+32:0] g_x_r, g_y_r;
  logic signed [VelW-1:0] g_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (adv) begin
      g_vld_r <= c_vld_r[NStg];
    end
    if (adv) begin
      g_x_r <= c_f_r[NStg] ? c_x_r[NStg] * $signed({1'b0, InvGain})
                           : (CorW+33)'(c_x_r[NStg]) <<< 32;
      g_y_r <= c_f_r[NStg] ? c_y_r[NStg] * $signed({1'b0, InvGain})
                           : (CorW+33)'(c_y_r[NStg]) <<< 32;
      g_w_r <= c_w_r[NStg];
    end
  end

  assign out_vld = g_vld_r;
  assign out_vel.vx = VelW'(g_x_r >>> 32);
  assign out_vel.vy = VelW'(g_y_r >>> 32);
  assign out_vel.w = g_w_r;
endmodule

/* rtl/core/smk_vector_pipe.sv */
// Vectoring CORDIC per module: atan2 and magnitude.
module smk_vector_pipe (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_vld,
  input  logic [1:0]             in_idx,
  input  logic signed [smk_pkg::VelW-1:0] in_vx,
  input  logic signed [smk_pkg::VelW-1:0] in_vy,
  output logic                   out_vld,
  output smk_pkg::res_t          out_res
);
  import smk_pkg::*;

  logic                   v_vld_r [NStg+1];
  logic signed [CorW-1:0] v_x_r [NStg+1];
  logic signed [CorW-1:0] v_y_r [NStg+1];
  logic [31:0]            v_z_r [NStg+1];
  logic [1:0]             v_i_r [NStg+1];
  logic                   v_zero_r [NStg+1];

  logic                   p_vld_r;
  logic signed [CorW-1:0] p_x_r, p_y_r;
  logic [31:0]            p_z_r;
  logic [1:0]             p_i_r;
  logic                   p_zero_r;
  logic signed [CorW-1:0] ex, ey;

  always_comb begin
    ex = CorW'(in_vx);
    ey = CorW'(in_vy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= in_vld;
    end
    if (adv) begin
      p_x_r <= ex[CorW-1] ? -ex : ex;
      p_y_r <= ex[CorW-1] ? -ey : ey;
      p_z_r <= ex[CorW-1] ? HalfTurn : 32'd0;
      p_i_r <= in_idx;
      p_zero_r <= (in_vx == '0) && (in_vy == '0);
    end
  end

  always_comb begin
    v_vld_r[0] = p_vld_r;
    v_x_r[0] = p_x_r;
    v_y_r[0] = p_y_r;
    v_z_r[0] = p_z_r;
    v_i_r[0] = p_i_r;
    v_zero_r[0] = p_zero_r;
  end

  for (genvar i = 0; i < NStg; i++) begin : g_vec
    logic signed [CorW-1:0] xs, ys;
    always_comb begin
      xs = v_x_r[i] >>> i;
      ys = v_y_r[i] >>> i;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_vld_r[i+1] <= v_vld_r[i];
      end
      if (adv) begin
        v_i_r[i+1] <= v_i_r[i];
        v_zero_r[i+1] <= v_zero_r[i];
        if (!v_y_r[i][CorW-1]) begin
          v_x_r[i+1] <= v_x_r[i] + ys;
          v_y_r[i+1] <= v_y_r[i] - xs;
          v_z_r[i+1] <= v_z_r[i] + atan_lut(5'(i));
        end else begin
          v_x_r[i+1] <= v_x_r[i] - ys;
          v_y_r[i+1] <= v_y_r[i] + xs;
          v_z_r[i+1] <= v_z_r[i] - atan_lut(5'(i));
        end
      end
    end
  end

  logic                    m_vld_r;
  logic signed [CorW+32:0] m_prod_r;
  logic [31:0]             m_z_r;
  logic [1:0]              m_i_r;
  logic                    m_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= v_vld_r[NStg];
    end
    if (adv) begin
      m_prod_r <= (v_x_r[NStg][CorW-1] || v_zero_r[NStg]) ? '0 :
                  v_x_r[NStg] * $signed({1'b0, InvGain});
      m_z_r <= v_zero_r[NStg] ? 32'd0 : v_z_r[NStg];
      m_i_r <= v_i_r[NStg];
      m_zero_r <= v_zero_r[NStg];
    end
  end

  logic [CorW:0]  mag;
  logic [CorW:0]  spd;
  logic [31:0]    ang_rnd;
  logic           o_vld_r;
  res_t           o_res_r;

  always_comb begin
    mag = (CorW+1)'(m_prod_r >>> 32);
    spd = (mag + (CorW+1)'(256)) >> 9;
    ang_rnd = m_z_r + 32'h0000_8000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= m_vld_r;
    end
    if (adv) begin
      o_res_r.module_index <= m_i_r;
      o_res_r.wheel_angle <= m_zero_r ? 16'sd0 : $signed(ang_rnd[31:16]);
      o_res_r.spd_q7 <= (spd > (CorW+1)'(65535)) ? 16'hFFFF : spd[15:0];
      o_res_r.last_module <= (m_i_r == MOD_BL);
    end
  end

  assign out_vld = o_vld_r;
  assign out_res = o_res_r;
endmodule

/* rtl/core/swerve_module_kinematics_top.sv */
// Swerve module inverse kinematics.
// in_*: one drive command per transaction (opcode, sticks, rotation, heading).
// out_*: four result transactions per command, modules 0..3 in order,
//   last_module marks module 3.
// cfg_*: write enable, index 0..7 and 14-bit data set module offsets.
//   Write only while idle.
// After each accepted command in_ready stays low while gap_r counts down on
//   advancing cycles, so the serializer that sends the four modules down the
//   shared vectoring CORDIC is free when the command arrives.
// A command passes the front pipeline, the serializer, the offset multiply and
//   sum registers and the vectoring CORDIC before its first result appears.
// The pipeline advances together; a low out_ready with a valid result freezes
//   every stage and the output register holds, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and the offsets.
module swerve_module_kinematics_top (
  input  logic                            clk,
  input  logic                            rst_n,
  smk_stream_if.sink                      in_if,
  smk_stream_if.source                    out_if,
  input  logic                            cfg_we,
  input  logic [smk_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [smk_pkg::CfgDataW-1:0]    cfg_data
);
  import smk_pkg::*;
  `include "swerve_module_kinematics_top_assert.svh"

  logic [CfgDataW-1:0] offs_r [NumRegs];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) offs_r[i] <= '0;
    end else if (cfg_we) begin
      offs_r[cfg_index] <= cfg_data;
    end
  end

  logic adv;
  logic o_vld;
  assign adv = !o_vld || out_if.ready;

  // serializer holds one command's velocities while it steps through the four modules
  logic       s_vld_r;
  logic [1:0] s_cnt_r;
  vel_t       s_vel_r;
  logic       f_vld;
  vel_t       f_vel;
  logic       take;
  logic [1:0] gap_r;

  assign in_if.ready = adv && (gap_r == 2'd0);
  assign take = in_if.valid && in_if.ready;

  // accepted commands are spaced apart by the gap_r countdown, which moves only on advancing cycles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
    end else if (adv) begin
      if (take) begin
        gap_r <= 2'd3;
      end else if (gap_r != 2'd0) begin
        gap_r <= gap_r - 2'd1;
      end
    end
  end

  smk_cmd_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(take), .in_cmd(cmd_t'(in_if.data)),
    .out_vld(f_vld), .out_vel(f_vel)
  );

  // the input spacing carries through the front pipeline, so the serializer
  // is free whenever f_vld rises
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      s_cnt_r <= 2'd0;
    end else if (adv) begin
      if (f_vld) begin
        s_vld_r <= 1'b1;
        s_cnt_r <= 2'd0;
      end else if (s_vld_r) begin
        s_vld_r <= (s_cnt_r != 2'd3);
        s_cnt_r <= s_cnt_r + 2'd1;
      end
    end
    if (adv && f_vld) s_vel_r <= f_vel;
  end

  // w * offset, floored
  logic                   k_vld_r;
  logic [1:0]             k_i_r;
  logic signed [VelW-1:0] k_vx_r, k_vy_r;
  logic signed [VelW+13:0] k_wy_r, k_wx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_vld_r <= 1'b0;
    end else if (adv) begin
      k_vld_r <= s_vld_r;
    end
    if (adv) begin
      k_i_r <= s_cnt_r;
      k_vx_r <= s_vel_r.vx;
      k_vy_r <= s_vel_r.vy;
      k_wy_r <= s_vel_r.w * $signed(offs_r[{s_cnt_r, 1'b1}]);
      k_wx_r <= s_vel_r.w * $signed(offs_r[{s_cnt_r, 1'b0}]);
    end
  end

  logic                   m_vld_r;
  logic [1:0]             m_i_r;
  logic signed [VelW-1:0] m_x_r, m_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= k_vld_r;
    end
    if (adv) begin
      m_i_r <= k_i_r;
      m_x_r <= k_vx_r - VelW'(k_wy_r >>> 8);
      m_y_r <= k_vy_r + VelW'(k_wx_r >>> 8);
    end
  end

  res_t o_res;

  smk_vector_pipe u_vec (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(m_vld_r), .in_idx(m_i_r), .in_vx(m_x_r), .in_vy(m_y_r),
    .out_vld(o_vld), .out_res(o_res)
  );

  assign out_if.valid = o_vld;
  assign out_if.data = o_res;

  `SMK_ASSERT_IMP(a_ser_free, clk, rst_n,
    adv && f_vld, !s_vld_r || (s_cnt_r == 2'd3))
  `SMK_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_if.valid && !out_if.ready, out_if.valid && $stable(out_if.data))
  `SMK_ASSERT_IMP(a_last_idx, clk, rst_n,
    out_if.valid, o_res.last_module == (o_res.module_index == MOD_BL))
endmodule

/* bench/swerve_module_kinematics_top_tb.sv */
`timescale 1ns / 100ps

module swerve_module_kinematics_top_tb;
  import smk_pkg::*;

  localparam int LATENCY = 2 * NStg + 20;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  smk_stream_if #(.W($bits(cmd_t))) in_ch ();
  smk_stream_if #(.W($bits(res_t))) out_ch ();

  swerve_module_kinematics_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [31:0] atan_step [24];
  logic [13:0] offset_regs [NumRegs];
  res_t wheel_results_due [$];
  int errors;
  int quiet_cycles;
  int ready_hold;
  bit no_idle;

  initial begin
    atan_step = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                  10679838, 5340245, 2670163, 1335087, 667544, 333772,
                  166886, 83443, 41722, 20861, 10430, 5215,
                  2608, 1304, 652, 326, 163, 81};
  end

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // heading rotation, gain removed
  function automatic void rotate_by(inout longint x, inout longint y, input logic [31:0] z);
    longint a, b, ax, by;
    a = x;
    b = y;
    if ($signed(z) > 32'sh4000_0000 || $signed(z) < -32'sh4000_0000) begin
      a = -a;
      b = -b;
      z = z + HalfTurn;
    end
    for (int i = 0; i < NStg; i++) begin
      ax = shr_floor(a, i);
      by = shr_floor(b, i);
      if ($signed(z) >= 0) begin
        a = a - by;
        b = b + ax;
        z = z - atan_step[i];
      end else begin
        a = a + by;
        b = b - ax;
        z = z + atan_step[i];
      end
    end
    x = shr_floor(a * 64'sd2608131496, 32);
    y = shr_floor(b * 64'sd2608131496, 32);
  endfunction

  function automatic void wheel_vector(input longint x, input longint y,
                                       output logic [31:0] ang, output longint mag);
    longint xs, ys;
    ang = '0;
    mag = 0;
    if (x == 0 && y == 0) return;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = HalfTurn;
    end
    for (int i = 0; i < NStg; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + atan_step[i];
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - atan_step[i];
      end
    end
    mag = (x < 0) ? 0 : shr_floor(x * 64'sd2608131496, 32);
  endfunction

  function automatic void predict_wheels(cmd_t c);
    longint fwd, side, rot, vx, vy, w, px, py, mx, my, mag, spd;
    logic [31:0] ang, rnd;
    logic [15:0] neg_head;
    res_t r;
    fwd = longint'(c.stick_forward);
    side = longint'(c.stick_sideways);
    rot = longint'(c.rotate_command);
    w = shr_floor(rot * 6487, 8);
    if (op_t'(c.opcode) == OP_FIELD) begin
      vx = shr_floor(-fwd * 51603, 8);
      vy = shr_floor(-side * 51603, 8);
      neg_head = -c.heading;
      rotate_by(vx, vy, {neg_head, 16'h0});
      if (rot > -1280 && rot < 1280) w = 0;
    end else begin
      vx = shr_floor(fwd * 51603, 8);
      vy = shr_floor(side * 51603, 8);
    end
    for (int k = 0; k < 4; k++) begin
      px = longint'($signed(offset_regs[2 * k]));
      py = longint'($signed(offset_regs[2 * k + 1]));
      mx = vx - shr_floor(w * py, 8);
      my = vy + shr_floor(w * px, 8);
      wheel_vector(mx, my, ang, mag);
      spd = (mag + 256) >>> 9;
      if (spd > 65535) spd = 65535;
      rnd = ang + 32'h8000;
      r.module_index = mod_idx_t'(k);
      r.wheel_angle = rnd[31:16];
      r.spd_q7 = spd[15:0];
      r.last_module = (mod_idx_t'(k) == MOD_BL);
      wheel_results_due.insert(wheel_results_due.size(), r);
    end
  endfunction

  task automatic report_mismatch(string what, longint expd, longint got);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, expd, got);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (wheel_results_due.size() == 0) begin
        report_mismatch("unexpected transaction, queue depth", 0, 1);
      end else begin
        want = wheel_results_due.pop_front();
        if (got.module_index !== want.module_index)
          report_mismatch("module_index", want.module_index, got.module_index);
        if (got.wheel_angle !== want.wheel_angle)
          report_mismatch("wheel_angle", want.wheel_angle, got.wheel_angle);
        if (got.spd_q7 !== want.spd_q7)
          report_mismatch("spd_q7", want.spd_q7, got.spd_q7);
        if (got.last_module !== want.last_module)
          report_mismatch("last_module", want.last_module, got.last_module);
      end
    end
  end

  // result-side backpressure
  always @(posedge clk) begin
    if (no_idle || !rst_n) begin
      out_ch.ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold <= $urandom_range(0, 18);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_cmd(cmd_t c);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= c;
    do @(posedge clk); while (!in_ch.ready);
    predict_wheels(c);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (wheel_results_due.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_offset(int idx, logic [13:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx[CfgIdxW-1:0];
    cfg_data <= val;
    offset_regs[idx] = val;
    @(posedge clk);
  endtask

  task automatic set_all_offsets(logic [13:0] v0, logic [13:0] v1, bit rnd);
    wait_drained();
    for (int i = 0; i < NumRegs; i++)
      write_offset(i, rnd ? 14'($urandom) : ((i % 2) ? v1 : v0));
    cfg_we <= 1'b0;
  endtask

  function automatic cmd_t make_cmd(op_t op, int f, int s, int r, int h);
    cmd_t c;
    c.opcode = op;
    c.stick_forward = f[15:0];
    c.stick_sideways = s[15:0];
    c.rotate_command = r[15:0];
    c.heading = h[15:0];
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.opcode = 1'($urandom_range(0, 1));
    c.stick_forward = 16'($urandom);
    c.stick_sideways = 16'($urandom);
    c.heading = 16'($urandom);
    case ($urandom_range(0, 3))
      0: c.rotate_command = 16'($urandom_range(0, 2559) - 1280);
      1: c.rotate_command = 16'($urandom_range(0, 8)) - 16'sd4;
      default: c.rotate_command = 16'($urandom);
    endcase
    return c;
  endfunction

  task automatic test_directed();
    send_cmd(make_cmd(OP_ROBOT, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_FIELD, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_ROBOT, 32767, 32767, 32767, 0));
    send_cmd(make_cmd(OP_ROBOT, -32768, -32768, -32768, 0));
    send_cmd(make_cmd(OP_ROBOT, -32768, 0, 0, 0));
    send_cmd(make_cmd(OP_ROBOT, 0, -256, 0, 0));
    send_cmd(make_cmd(OP_FIELD, 256, 0, 1279, 16384));
    send_cmd(make_cmd(OP_FIELD, 256, 0, -1279, -16384));
    send_cmd(make_cmd(OP_FIELD, 256, 256, 1280, -32768));
    send_cmd(make_cmd(OP_FIELD, -256, 512, -1280, 32767));
    send_cmd(make_cmd(OP_FIELD, 32767, -32768, 32767, 8192));
    send_cmd(make_cmd(OP_FIELD, -32768, 32767, -32768, -8192));
    send_cmd(make_cmd(OP_ROBOT, 0, 0, 32767, 12345));
    send_cmd(make_cmd(OP_ROBOT, 0, 0, -32768, 0));
  endtask

  task automatic test_offset_extremes();
    set_all_offsets(14'h1FFF, 14'h1FFF, 0);
    test_directed();
    set_all_offsets(14'h2000, 14'h2000, 0);
    test_directed();
    set_all_offsets(14'h1FFF, 14'h2000, 0);
    send_cmd(make_cmd(OP_ROBOT, 0, 0, 32767, 0));
    send_cmd(make_cmd(OP_ROBOT, 32767, -32768, -32768, 0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) set_all_offsets('0, '0, 1);
      send_cmd(random_cmd());
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
    for (int i = 0; i < 10; i++) send_cmd(random_cmd());
  endtask

  task automatic test_streaming(int n);
    set_all_offsets('0, '0, 1);
    no_idle = 1;
    for (int i = 0; i < n; i++) send_cmd(random_cmd());
  endtask

  initial begin
    errors = 0;
    no_idle = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NumRegs; i++) offset_regs[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_offset_extremes();
    test_random(296);
    test_drain_pause();
    test_streaming(80);
    wait_drained();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
